### sv/ttrc_pkg.sv
// Package for the three-term recurrence checksum.
// Holds field widths, recurrence constants and the term-state struct.
// No dependencies.
package ttrc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TERM_W  = 16;
  localparam int unsigned INDEX_W = 8;

  // Recurrence constants
  localparam logic [BYTE_W-1:0]  FIRST_OFFSET = 8'd7;
  localparam logic [INDEX_W-1:0] ALPHA_MUL    = 8'd17;
  localparam logic [INDEX_W-1:0] BETA_MUL     = 8'd31;
  localparam logic [TERM_W-1:0]  MOD_VALUE    = 16'hFFFF;
  localparam logic [TERM_W-1:0]  OLDER_INIT   = 16'd1;

  // Running state of one message
  typedef struct packed {
    logic [TERM_W-1:0]  older;
    logic [TERM_W-1:0]  newer;
    logic [INDEX_W-1:0] index;
    logic               first;
  } ttrc_state_t;

  localparam ttrc_state_t STATE_INIT = '{
    older: OLDER_INIT,
    newer: '0,
    index: '0,
    first: 1'b1
  };

endpackage

### sv/ttrc_if.sv
// Valid/ready channel interfaces for the checksum block.
// Depends on ttrc_pkg for field widths.
interface ttrc_in_if
  import ttrc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ttrc_out_if
  import ttrc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [TERM_W-1:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

### sv/three_term_recurrence_checksum.sv
// Top level of the three-term recurrence checksum.
// Depends on ttrc_pkg, ttrc_in_if/ttrc_out_if and ttrc_step.
//
// Usage:
//   in_if  : one message byte per beat, last_byte set on the final beat.
//            Messages follow each other with no gap; empty messages are
//            not supported.
//   out_if : one beat per message carrying the 16-bit checksum.
// Path: a final byte is held in the input register, and its checksum is
//   written to the result register when the step stage advances
//   (one input register, one state/result register).
// Throughput: one byte per cycle unless a final byte waits on a stalled
//   result beat. The limit is the state loop (four multiplies, subtract,
//   end-around fold) that feeds the newer/older term registers.
// Reset: rst_n (synchronous, active low) empties both registers and puts the
//   recurrence state back to its start; in_ready is low during reset.
// Stall: while out_ready is low the checksum beat holds. Non-final bytes
//   keep flowing; a final byte waits in the input register until the
//   result register frees, and in_ready then drops until it moves on.
module three_term_recurrence_checksum
  import ttrc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  ttrc_in_if.sink         in_if,
  ttrc_out_if.source      out_if
);

  logic              in_v_r;
  logic [BYTE_W-1:0] byte_r;
  logic              last_r;
  ttrc_state_t       state_r;
  ttrc_state_t       state_nxt;
  logic              out_v_r;
  logic [TERM_W-1:0] checksum_r;
  logic [TERM_W-1:0] checksum_nxt;
  logic              advance;
  logic              in_take;

  // Step stage moves unless it carries a result and the output beat is stalled
  assign advance   = in_v_r && (!last_r || !out_v_r || out_if.ready);
  assign in_if.ready = rst_n && (!in_v_r || advance);
  assign in_take   = in_if.valid && in_if.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_if.data_byte;
      last_r <= in_if.last_byte;
    end
  end

  ttrc_step u_step (
    .data_byte (byte_r),
    .last_byte (last_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .checksum  (checksum_nxt)
  );

  // Recurrence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_INIT;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && last_r) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_r) begin
      checksum_r <= checksum_nxt;
    end
  end

  assign out_if.valid    = out_v_r;
  assign out_if.checksum = checksum_r;

endmodule

### sv/ttrc_step.sv
// Combinational next-state logic: one recurrence step for one byte.
// Depends on ttrc_pkg for widths, constants and ttrc_state_t.
module ttrc_step
  import ttrc_pkg::*;
(
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_byte,
  input  ttrc_state_t       state_cur,
  output ttrc_state_t       state_nxt,
  output logic [TERM_W-1:0] checksum
);

  logic [2*INDEX_W-1:0] alpha_full;
  logic [2*INDEX_W-1:0] beta_full;
  logic [INDEX_W-1:0]   alpha;
  logic [INDEX_W-1:0]   beta;
  logic [BYTE_W:0]      coef_a;
  logic [BYTE_W+TERM_W:0]   prod_a;
  logic [INDEX_W+TERM_W-1:0] prod_b;
  logic                 a_ge_b;
  logic [BYTE_W+TERM_W:0]   mag;
  logic [TERM_W:0]      fold;
  logic [TERM_W-1:0]    red;
  logic [TERM_W-1:0]    term;
  logic [TERM_W-1:0]    newer_upd;

  // Index coefficients, mod 256
  assign alpha_full = state_cur.index * ALPHA_MUL;
  assign beta_full  = state_cur.index * BETA_MUL;
  assign alpha      = alpha_full[INDEX_W-1:0];
  assign beta       = beta_full[INDEX_W-1:0];

  // The two products
  assign coef_a = {1'b0, data_byte} + {1'b0, alpha};
  assign prod_a = coef_a * state_cur.newer;
  assign prod_b = beta * state_cur.older;
  assign a_ge_b = prod_a >= {1'b0, prod_b};

  // Magnitude: a-b, or b-a-1 when negative (2^64 wrap adds one)
  assign mag = a_ge_b ? (prod_a - {1'b0, prod_b})
                      : ({1'b0, prod_b} - prod_a - 1'b1);

  // Mod 65535 by end-around fold, then one conditional subtract
  assign fold = {1'b0, mag[TERM_W-1:0]}
              + {{(TERM_W-BYTE_W){1'b0}}, mag[BYTE_W+TERM_W:TERM_W]};
  assign red  = (fold >= {1'b0, MOD_VALUE}) ? TERM_W'(fold - {1'b0, MOD_VALUE})
                                            : fold[TERM_W-1:0];

  // Negative difference maps to the additive inverse
  always_comb begin
    if (a_ge_b) begin
      term = red;
    end else if (red == '0) begin
      term = '0;
    end else begin
      term = MOD_VALUE - red;
    end
  end

  // State update
  always_comb begin
    if (state_cur.first) begin
      newer_upd = TERM_W'(data_byte) + TERM_W'(FIRST_OFFSET);
    end else begin
      newer_upd = term;
    end
    checksum = newer_upd;
    if (last_byte) begin
      state_nxt = STATE_INIT;
    end else if (state_cur.first) begin
      state_nxt.older = OLDER_INIT;
      state_nxt.newer = newer_upd;
      state_nxt.index = INDEX_W'(1);
      state_nxt.first = 1'b0;
    end else begin
      state_nxt.older = state_cur.newer;
      state_nxt.newer = newer_upd;
      state_nxt.index = state_cur.index + 1'b1;
      state_nxt.first = 1'b0;
    end
  end

endmodule

### sv/ttrc_checker.sv
// Port-level checker for the checksum block, bound to the top level.
// Depends on ttrc_pkg for widths and the modulus.
module ttrc_checker
  import ttrc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input logic [TERM_W-1:0] out_checksum
);

  // A stalled result beat holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_checksum))
    else $error("checksum beat changed while stalled");

  // Residues mod 65535 never reach the modulus
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_checksum != MOD_VALUE)
    else $error("checksum out of range");

  // A new result rises once its final byte has passed the input and result registers
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result without a final byte two cycles earlier");

  // No input beat is taken in reset
  assert property (@(posedge clk)
    !rst_n |-> !in_ready)
    else $error("input ready during reset");

endmodule

bind three_term_recurrence_checksum ttrc_checker u_ttrc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .in_last      (in_if.last_byte),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_checksum (out_if.checksum)
);
